// File: hdl/afc_pkg.sv
package afc_pkg;

	localparam int IN_W = 32;
	localparam int SEL_MODEL = 0;
	localparam int SEL_VIEW = 1;
	localparam int SEL_PROJ = 2;
	localparam int SEL_UNUSED = 3;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_BOX = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [1:0]        matrix_select;
		logic [3:0]        entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} in_item_t;

	typedef struct packed {
		logic       visible;
		logic [5:0] shared_outside;
		logic       overflowed;
	} out_item_t;

endpackage

// File: hdl/afc_xform.sv
// one 4x4 row-vector transform; four stages: multiply, pair sums, total, narrow
module afc_xform #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vld,
	input  logic                         ovf,
	input  logic signed [WORD_WIDTH-1:0] vec [4],
	input  logic signed [WORD_WIDTH-1:0] mat [16],
	output logic                         vld_o,
	output logic                         ovf_o,
	output logic signed [WORD_WIDTH-1:0] res [4]
);
	localparam int PW = 2 * WORD_WIDTH;
	localparam int SW = PW + 2;
	localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	logic signed [PW-1:0] prod_s1 [16];
	logic signed [SW-1:0] pair_s2 [8];
	logic signed [SW-1:0] sum_s3 [4];
	logic [2:0] vld_q;
	logic [2:0] ovf_q;
	logic signed [WORD_WIDTH-1:0] res_s4 [4];
	logic vld_s4, ovf_s4;
	logic [3:0] sat;
	logic signed [WORD_WIDTH-1:0] nar [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					prod_s1[c*4+r] <= PW'(vec[r]) * PW'(mat[r*4+c]);
				end
				pair_s2[c*2]   <= SW'(prod_s1[c*4])   + SW'(prod_s1[c*4+1]);
				pair_s2[c*2+1] <= SW'(prod_s1[c*4+2]) + SW'(prod_s1[c*4+3]);
				sum_s3[c] <= pair_s2[c*2] + pair_s2[c*2+1];
				res_s4[c] <= nar[c];
			end
		end
	end

	always_comb begin
		logic signed [SW-1:0] sh;
		sh = '0;
		for (int c = 0; c < 4; c++) begin
			sh = sum_s3[c] >>> FRAC_BITS;
			if (sh > SW'(WMAX)) begin
				nar[c] = WMAX;
				sat[c] = 1'b1;
			end else if (sh < SW'(WMIN)) begin
				nar[c] = WMIN;
				sat[c] = 1'b1;
			end else begin
				nar[c] = sh[WORD_WIDTH-1:0];
				sat[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[1:0], vld};
			vld_s4 <= vld_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ovf_q <= {ovf_q[1:0], ovf};
			ovf_s4 <= ovf_q[2] | (|sat);
		end
	end

	assign vld_o = vld_s4;
	assign ovf_o = ovf_s4;
	assign res = res_s4;
endmodule

// File: hdl/aabb_frustum_cull_unit.sv
// aabb frustum cull unit
// in channel: in_valid / in_stall / in_data (afc_pkg::in_item_t)
//   mode 0 transfers write one matrix entry (model, view, projection),
//   selecting matrix 3 is ignored; they give no result
//   mode 1 transfers test a box: its eight corners are sent through
//   model, view and projection transforms, one corner per unfrozen cycle
// out channel: out_valid / out_stall / out_data (afc_pkg::out_item_t),
//   one transfer per box
// throughput: one load per cycle unless frozen or busy; a new item is
//   taken once the last corner of a box has issued (the corner
//   sequencer feeds the single shared transform chain one corner a cycle)
// result path: issue register, three 4-stage transforms, output register;
//   the result follows the box's last corner, and waits while frozen
// view and projection writes take effect late so that boxes
//   already in flight finish with the matrices they started with
// reset: all matrices read as zero (48 valid bits cleared), pipeline empty
// stall: out_stall on a held result freezes the whole pipeline; in_stall
//   rises during a box split or a freeze, nothing is lost or repeated
module aabb_frustum_cull_unit #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  afc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output afc_pkg::out_item_t  out_data
);
	localparam int W = WORD_WIDTH;
	localparam int IW = afc_pkg::IN_W;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// matrix store: valid bits give reset-to-zero
	logic signed [W-1:0] mat_q [48];
	logic [47:0] mvalid_q;
	logic signed [W-1:0] mview [3][16];

	// pipeline advances whenever the output is free
	logic adv;
	assign adv = !(out_valid && out_stall);

	logic in_xfer;
	logic [2:0] corner_q;
	logic busy_q;
	logic signed [W-1:0] lo_q [3];
	logic signed [W-1:0] hi_q [3];
	logic bovf_q;

	assign in_stall = !adv || busy_q;
	assign in_xfer = in_valid && !in_stall;

	// saturate a 32-bit input into the word
	function automatic logic signed [W:0] sat_in(input logic signed [IW-1:0] v);
		logic signed [W:0] r;
		logic signed [IW+W-1:0] x;
		x = (IW+W)'(v);
		if (x > (IW+W)'(WMAX)) r = {1'b1, WMAX};
		else if (x < (IW+W)'(WMIN)) r = {1'b1, WMIN};
		else r = {1'b0, x[W-1:0]};
		return r;
	endfunction

	logic signed [W:0] s_lo [3];
	logic signed [W:0] s_hi [3];
	logic signed [W:0] s_ev;
	assign s_lo[0] = sat_in(in_data.box_min_x);
	assign s_lo[1] = sat_in(in_data.box_min_y);
	assign s_lo[2] = sat_in(in_data.box_min_z);
	assign s_hi[0] = sat_in(in_data.box_max_x);
	assign s_hi[1] = sat_in(in_data.box_max_y);
	assign s_hi[2] = sat_in(in_data.box_max_z);
	assign s_ev = sat_in(in_data.entry_value);

	// w = 1.0 may not fit at small word widths
	localparam bit ONE_OVF = (FRAC_BITS >= W - 1);
	localparam logic signed [W-1:0] ONE_W = ONE_OVF ? WMAX : W'(1) << FRAC_BITS;

	// model writes land at once; view and projection writes ride a short
	// queue that moves with the pipeline, so they land just after the
	// last corner of an earlier box has read the old entry
	logic ld_xfer;
	logic wr_model, wr_view, wr_proj;
	logic [7:0] wr_vld_q;
	logic [1:0] wr_sel_q [8];
	logic [3:0] wr_idx_q [8];
	logic signed [W-1:0] wr_val_q [8];

	assign ld_xfer = in_xfer && in_data.mode == afc_pkg::MODE_LOAD
		&& in_data.matrix_select != 2'(afc_pkg::SEL_UNUSED);
	assign wr_model = ld_xfer && in_data.matrix_select == 2'(afc_pkg::SEL_MODEL);
	assign wr_view = adv && wr_vld_q[3] && wr_sel_q[3] == 2'(afc_pkg::SEL_VIEW);
	assign wr_proj = adv && wr_vld_q[7] && wr_sel_q[7] == 2'(afc_pkg::SEL_PROJ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= '0;
		end else if (adv) begin
			wr_vld_q <= {wr_vld_q[6:0], ld_xfer && !wr_model};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_sel_q[0] <= in_data.matrix_select;
			wr_idx_q[0] <= in_data.entry_index;
			wr_val_q[0] <= s_ev[W-1:0];
			for (int k = 1; k < 8; k++) begin
				wr_sel_q[k] <= wr_sel_q[k-1];
				wr_idx_q[k] <= wr_idx_q[k-1];
				wr_val_q[k] <= wr_val_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= '0;
		end else begin
			if (wr_model) mvalid_q[{in_data.matrix_select, in_data.entry_index}] <= 1'b1;
			if (wr_view) mvalid_q[{wr_sel_q[3], wr_idx_q[3]}] <= 1'b1;
			if (wr_proj) mvalid_q[{wr_sel_q[7], wr_idx_q[7]}] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_model) mat_q[{in_data.matrix_select, in_data.entry_index}] <= s_ev[W-1:0];
		if (wr_view) mat_q[{wr_sel_q[3], wr_idx_q[3]}] <= wr_val_q[3];
		if (wr_proj) mat_q[{wr_sel_q[7], wr_idx_q[7]}] <= wr_val_q[7];
	end

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			for (int e = 0; e < 16; e++) begin
				mview[m][e] = mvalid_q[m*16+e] ? mat_q[m*16+e] : '0;
			end
		end
	end

	// corner sequencer
	logic any_sat;
	always_comb begin
		any_sat = ONE_OVF;
		for (int i = 0; i < 3; i++) any_sat |= s_lo[i][W] | s_hi[i][W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			corner_q <= '0;
		end else if (adv) begin
			if (in_xfer && in_data.mode == afc_pkg::MODE_BOX) begin
				busy_q <= 1'b1;
				corner_q <= 3'd1;
			end else if (busy_q) begin
				corner_q <= corner_q + 3'd1;
				if (corner_q == 3'd7) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_xfer && in_data.mode == afc_pkg::MODE_BOX) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= s_lo[i][W-1:0];
				hi_q[i] <= s_hi[i][W-1:0];
			end
			bovf_q <= any_sat;
		end
	end

	// corner issue register
	logic vec_vld_s0, vec_last_s0, vec_ovf_s0;
	logic signed [W-1:0] vec_s0 [4];
	logic [2:0] cn;
	logic issue;
	logic first;
	assign first = in_xfer && in_data.mode == afc_pkg::MODE_BOX;
	assign issue = busy_q;
	assign cn = corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_vld_s0 <= 1'b0;
		end else if (adv) begin
			vec_vld_s0 <= first || issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (first) begin
				vec_s0[0] <= s_lo[0][W-1:0];
				vec_s0[1] <= s_lo[1][W-1:0];
				vec_s0[2] <= s_lo[2][W-1:0];
				vec_ovf_s0 <= any_sat;
				vec_last_s0 <= 1'b0;
			end else begin
				vec_s0[0] <= cn[0] ? hi_q[0] : lo_q[0];
				vec_s0[1] <= cn[1] ? hi_q[1] : lo_q[1];
				vec_s0[2] <= cn[2] ? hi_q[2] : lo_q[2];
				vec_ovf_s0 <= bovf_q;
				vec_last_s0 <= cn == 3'd7;
			end
			vec_s0[3] <= ONE_W;
		end
	end

	// last-corner flag travels alongside the transforms
	logic [11:0] last_q;
	always_ff @(posedge clk) begin
		if (adv) last_q <= {last_q[10:0], vec_last_s0};
	end

	logic v1, v2, v3, o1, o2, o3;
	logic signed [W-1:0] r1 [4];
	logic signed [W-1:0] r2 [4];
	logic signed [W-1:0] r3 [4];

	afc_xform #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_model (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vld(vec_vld_s0), .ovf(vec_ovf_s0),
		.vec(vec_s0), .mat(mview[afc_pkg::SEL_MODEL]), .vld_o(v1), .ovf_o(o1), .res(r1));
	afc_xform #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_view (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vld(v1), .ovf(o1),
		.vec(r1), .mat(mview[afc_pkg::SEL_VIEW]), .vld_o(v2), .ovf_o(o2), .res(r2));
	afc_xform #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_proj (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vld(v2), .ovf(o2),
		.vec(r2), .mat(mview[afc_pkg::SEL_PROJ]), .vld_o(v3), .ovf_o(o3), .res(r3));

	// outcodes: 3x against 4w, y and z against w
	logic [5:0] code;
	always_comb begin
		logic signed [W+2:0] vx, lx, vy, vz, lw;
		vx = (W+3)'(r3[0]) * (W+3)'(3);
		lx = (W+3)'(r3[3]) <<< 2;
		vy = (W+3)'(r3[1]);
		vz = (W+3)'(r3[2]);
		lw = (W+3)'(r3[3]);
		code[0] = vx < -lx;
		code[1] = vx > lx;
		code[2] = vy < -lw;
		code[3] = vy > lw;
		code[4] = vz < -lw;
		code[5] = vz > lw;
	end

	// accumulate over the eight corners
	logic [5:0] acc_q;
	logic aovf_q;
	logic [5:0] acc_n;
	logic aovf_n;
	logic last_c;
	assign last_c = last_q[11];
	assign acc_n = acc_q & code;
	assign aovf_n = aovf_q | o3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 6'd63;
			aovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv && v3 && last_c) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (adv && v3) begin
				if (last_c) begin
					acc_q <= 6'd63;
					aovf_q <= 1'b0;
					out_data.overflowed <= aovf_n;
					out_data.visible <= !aovf_n && acc_n == 6'd0;
					out_data.shared_outside <= aovf_n ? 6'd0 : acc_n;
				end else begin
					acc_q <= acc_n;
					aovf_q <= aovf_n;
				end
			end
		end
	end

	// a result means overflowed forces culled
	a_ovf_culled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflowed |-> !out_data.visible
		&& out_data.shared_outside == 6'd0)
		else $error("overflowed result not culled");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall)
		else $error("input taken while corners pending");
	a_vis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.visible |-> out_data.shared_outside == 6'd0)
		else $error("visible with shared plane");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
endmodule

// File: tb/afc_cull_checker.sv
`timescale 1ns / 100ps

module afc_cull_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  afc_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  afc_pkg::out_item_t out_data,
	output int                 fail_count,
	output int                 pending
);
	localparam logic signed [79:0] WORD_MAX = 80'sh7fffffff;
	localparam logic signed [79:0] WORD_MIN = -80'sh80000000;

	logic signed [31:0] mat_copy [48];
	afc_pkg::out_item_t verdict_q [$];

	function automatic logic signed [31:0] narrow_sum(logic signed [79:0] s, inout bit ovf);
		logic signed [79:0] t;
		t = s >>> 16;
		if (t > WORD_MAX) begin
			ovf = 1;
			return 32'sh7fffffff;
		end
		if (t < WORD_MIN) begin
			ovf = 1;
			return 32'sh80000000;
		end
		return t[31:0];
	endfunction

	function automatic void apply_matrix(input int sel, input logic signed [31:0] v [4],
			output logic signed [31:0] o [4], inout bit ovf);
		logic signed [79:0] acc, a, b;
		for (int c = 0; c < 4; c++) begin
			acc = 0;
			for (int r = 0; r < 4; r++) begin
				a = v[r];
				b = mat_copy[sel * 16 + r * 4 + c];
				acc += a * b;
			end
			o[c] = narrow_sum(acc, ovf);
		end
	endfunction

	function automatic afc_pkg::out_item_t cull_box(afc_pkg::in_item_t it);
		afc_pkg::out_item_t res;
		logic signed [31:0] lo [3], hi [3], p [4], q [4];
		logic signed [63:0] val, lim;
		logic [5:0] shared, code;
		bit ovf;
		ovf = 0;
		shared = 6'h3f;
		lo[0] = it.box_min_x; lo[1] = it.box_min_y; lo[2] = it.box_min_z;
		hi[0] = it.box_max_x; hi[1] = it.box_max_y; hi[2] = it.box_max_z;
		for (int k = 0; k < 8; k++) begin
			for (int i = 0; i < 3; i++)
				p[i] = k[i] ? hi[i] : lo[i];
			p[3] = 32'sh10000;
			apply_matrix(afc_pkg::SEL_MODEL, p, q, ovf);
			apply_matrix(afc_pkg::SEL_VIEW, q, p, ovf);
			apply_matrix(afc_pkg::SEL_PROJ, p, q, ovf);
			code = 0;
			for (int i = 0; i < 3; i++) begin
				val = q[i];
				lim = q[3];
				// x plane sits at 4/3 w, compared without division
				if (i == 0) begin
					val = val * 3;
					lim = lim * 4;
				end
				if (val < -lim) code[2 * i] = 1;
				if (val > lim) code[2 * i + 1] = 1;
			end
			shared &= code;
		end
		res.overflowed = ovf;
		res.shared_outside = ovf ? 6'd0 : shared;
		res.visible = !ovf && shared == 0;
		return res;
	endfunction

	assign pending = verdict_q.size();

	always @(posedge clk or negedge arst_n) begin
		afc_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < 48; i++)
				mat_copy[i] = 0;
			verdict_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result %p", $realtime, out_data);
				end else begin
					want = verdict_q.pop_front();
					if (out_data.visible !== want.visible
							|| out_data.shared_outside !== want.shared_outside
							|| out_data.overflowed !== want.overflowed) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp %p got %p", $realtime, want, out_data);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.mode == afc_pkg::MODE_BOX)
					verdict_q.push_back(cull_box(in_data));
				else if (in_data.matrix_select <= afc_pkg::SEL_PROJ)
					mat_copy[in_data.matrix_select * 16 + in_data.entry_index] = in_data.entry_value;
			end
		end
	end

endmodule

// File: tb/aabb_frustum_cull_unit_test.sv
`timescale 1ns / 100ps

module aabb_frustum_cull_unit_test;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic signed [31:0] ONE = 32'sh10000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	afc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	afc_pkg::out_item_t out_data;
	int fail_count;
	int pending;
	int cycles = 0;
	int stall_style = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	aabb_frustum_cull_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	afc_cull_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern, one of four styles redrawn at random during the run
	always @(negedge clk) begin
		if (cycles % 300 == 0)
			stall_style <= $urandom_range(0, 3);
		case (stall_style)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ((cycles / 23) % 3 == 0);
		endcase
	end

	// sender burst state: items left in the current burst
	int burst_left = 0;

	// present one item at the falling edge, hold it until the transfer
	task automatic push_item(input afc_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			// gap between bursts: drop valid for a while
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_data <= it;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic afc_pkg::in_item_t rand_item;
		return afc_pkg::in_item_t'(($bits(afc_pkg::in_item_t))'({$urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
	endfunction

	task automatic load_entry(input int sel, input int idx, input logic signed [31:0] v);
		afc_pkg::in_item_t it;
		it = rand_item();
		it.mode = afc_pkg::MODE_LOAD;
		it.matrix_select = 2'(sel);
		it.entry_index = 4'(idx);
		it.entry_value = v;
		push_item(it);
	endtask

	task automatic test_box(input logic signed [31:0] x0, y0, z0, x1, y1, z1);
		afc_pkg::in_item_t it;
		it = rand_item();
		it.mode = afc_pkg::MODE_BOX;
		it.box_min_x = x0; it.box_min_y = y0; it.box_min_z = z0;
		it.box_max_x = x1; it.box_max_y = y1; it.box_max_z = z1;
		push_item(it);
	endtask

	task automatic load_identity(input int sel);
		for (int i = 0; i < 16; i++)
			load_entry(sel, i, (i % 5 == 0) ? ONE : 32'sd0);
	endtask

	// hold the sender until every box result is back
	task automatic drain;
		in_valid <= 0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_fix;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: return 0;
			default: return $signed($urandom_range(0, 32'h8ffff)) - 32'sh48000;
		endcase
	endfunction

	initial begin
		afc_pkg::in_item_t it;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// all matrices zero after reset: w is zero, nothing is outside
		test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		load_identity(afc_pkg::SEL_MODEL);
		load_identity(afc_pkg::SEL_VIEW);
		load_identity(afc_pkg::SEL_PROJ);
		// unused select must not disturb the model matrix
		load_entry(afc_pkg::SEL_UNUSED, 0, 32'sh7fffffff);
		test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		test_box(3 * ONE, -ONE, -ONE, 4 * ONE, ONE, ONE);
		test_box(-ONE, -4 * ONE, -ONE, ONE, -2 * ONE, ONE);
		test_box(-ONE, -ONE, 2 * ONE, ONE, ONE, 5 * ONE);
		// swapped corners and word extremes
		test_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		test_box(32'sh80000000, 0, 0, 32'sh80000000, 0, 0);
		// negative w gives both bits of an axis
		load_entry(afc_pkg::SEL_PROJ, 15, -ONE);
		test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
		// a huge scale saturates the transform
		load_entry(afc_pkg::SEL_MODEL, 0, 32'sh7fffffff);
		test_box(32'sh7fffffff, 0, 0, 32'sh7fffffff, ONE, ONE);
		drain;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it = rand_item();
			if ($urandom_range(0, 9) < 3) begin
				it.mode = afc_pkg::MODE_LOAD;
				// mostly near-identity matrices so boxes straddle the frustum
				if ($urandom_range(0, 3) != 0)
					it.entry_value = (it.entry_index % 5 == 0) ? ONE + rand_fix() / 4
						: rand_fix() / 8;
				else
					it.entry_value = rand_fix();
			end else begin
				it.mode = afc_pkg::MODE_BOX;
				if ($urandom_range(0, 7) != 0) begin
					it.box_min_x = rand_fix(); it.box_min_y = rand_fix();
					it.box_min_z = rand_fix();
					it.box_max_x = it.box_min_x + $urandom_range(0, 32'h30000);
					it.box_max_y = it.box_min_y + $urandom_range(0, 32'h30000);
					it.box_max_z = it.box_min_z + $urandom_range(0, 32'h30000);
				end
			end
			push_item(it);
			if (n == RANDOM_ITEMS / 2)
				drain;
		end
		drain;

		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: aabb_frustum_cull_unit.f
hdl/afc_pkg.sv
hdl/afc_xform.sv
hdl/aabb_frustum_cull_unit.sv
tb/afc_cull_checker.sv
tb/aabb_frustum_cull_unit_test.sv
